/* src/dqs_pkg.sv */
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types and constants for the double-ended queue store unit.
// ----------------------------------------------------------------------------
package dqs_pkg;

   // Fixed field widths of the request and response items
   localparam int CMD_WIDTH    = 2;
   localparam int INDEX_WIDTH  = 6;
   localparam int STATUS_WIDTH = 2;

   // Command codes carried by a request item
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD_FRONT = 2'd0,
      CMD_ADD_BACK  = 2'd1,
      CMD_READ      = 2'd2,
      CMD_CLEAR     = 2'd3
   } cmd_type;

   // Status codes carried by a response item
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_BUSY = 1'b1
   } state_type;

   // Command from controller to datapath
   typedef struct packed {
      logic load;
   } dp_cmd_type;

endpackage

/* src/dqs_req_if.sv */
// ----------------------------------------------------------------------------
// dqs_req_if
// Request channel: valid/ready handshake plus command, value and index.
// ----------------------------------------------------------------------------
interface dqs_req_if
   import dqs_pkg::*;
#(
   parameter int DATA_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic [CMD_WIDTH-1:0]   cmd;
   logic [DATA_WIDTH-1:0]  value;
   logic [INDEX_WIDTH-1:0] index;

   modport source (output valid, output cmd, output value, output index, input ready);
   modport sink   (input valid, input cmd, input value, input index, output ready);
endinterface

/* src/dqs_rsp_if.sv */
// ----------------------------------------------------------------------------
// dqs_rsp_if
// Response channel: valid/ready handshake plus read, front, back, count,
// empty flag and status.
// ----------------------------------------------------------------------------
interface dqs_rsp_if
   import dqs_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int CAPACITY   = 64
);
   localparam int CW = $clog2(CAPACITY + 1);

   logic                    valid;
   logic                    ready;
   logic [DATA_WIDTH-1:0]   read_value;
   logic [DATA_WIDTH-1:0]   front_value;
   logic [DATA_WIDTH-1:0]   back_value;
   logic [CW-1:0]           count;
   logic                    is_empty;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, output read_value, output front_value, output back_value,
                   output count, output is_empty, output status, input ready);
   modport sink   (input valid, input read_value, input front_value, input back_value,
                   input count, input is_empty, input status, output ready);
endinterface

/* src/dqs_ctrl.sv */
// ----------------------------------------------------------------------------
// dqs_ctrl
// Handshake controller: takes a request item, holds the response item until
// taken, and accepts the next request in the same cycle a response leaves.
// ----------------------------------------------------------------------------
module dqs_ctrl
   import dqs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type dp_cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake outputs
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      dp_cmd.load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            rsp_valid   = 1'b1;
            // a new item may enter as the held result leaves
            req_ready   = rsp_ready;
            dp_cmd.load = req_valid && rsp_ready;
            if (rsp_ready && !req_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/dqs_datapath.sv */
// ----------------------------------------------------------------------------
// dqs_datapath
// Ring store, front position, element count, cached front and back values
// and the registered result fields.
// ----------------------------------------------------------------------------
module dqs_datapath
   import dqs_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int CAPACITY   = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              dp_cmd,
   input  logic [CMD_WIDTH-1:0]    cmd,
   input  logic [DATA_WIDTH-1:0]   value,
   input  logic [INDEX_WIDTH-1:0]  index,
   output logic [DATA_WIDTH-1:0]   read_value,
   output logic [DATA_WIDTH-1:0]   front_value,
   output logic [DATA_WIDTH-1:0]   back_value,
   output logic [$clog2(CAPACITY+1)-1:0] count,
   output logic                    is_empty,
   output logic [STATUS_WIDTH-1:0] status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (CW > INDEX_WIDTH ? CW : INDEX_WIDTH) + 1;

   // Ring store
   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [AW-1:0]         front_pos_ff, front_pos_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] front_val_ff, front_val_in;
   logic [DATA_WIDTH-1:0] back_val_ff, back_val_in;
   status_type            status_ff, status_in;
   logic                  rd_sel_ff, rd_sel_in;
   logic [DATA_WIDTH-1:0] rd_q_ff;

   cmd_type         cmd_in;
   logic            full;
   logic            in_range;
   logic [AW-1:0]   front_dec;
   logic [SW-1:0]   back_sum;
   logic [SW-1:0]   read_sum;
   logic [AW-1:0]   back_pos;
   logic [AW-1:0]   read_pos;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic            rd_en;

   // Ring arithmetic: sums stay below twice the capacity, one subtract wraps
   always_comb begin
      cmd_in    = cmd_type'(cmd);
      full      = (cnt_ff == CW'(CAPACITY));
      in_range  = (SW'(index) < SW'(cnt_ff));
      front_dec = (front_pos_ff == '0) ? AW'(CAPACITY - 1) : front_pos_ff - AW'(1);
      back_sum  = SW'(front_pos_ff) + SW'(cnt_ff);
      read_sum  = SW'(front_pos_ff) + SW'(index);
      back_pos  = (back_sum >= SW'(CAPACITY)) ? AW'(back_sum - SW'(CAPACITY)) : AW'(back_sum);
      read_pos  = (read_sum >= SW'(CAPACITY)) ? AW'(read_sum - SW'(CAPACITY)) : AW'(read_sum);
   end

   // Command decode and next state
   always_comb begin
      front_pos_in = front_pos_ff;
      cnt_in       = cnt_ff;
      front_val_in = front_val_ff;
      back_val_in  = back_val_ff;
      status_in    = status_ff;
      rd_sel_in    = rd_sel_ff;
      wr_en        = 1'b0;
      wr_addr      = back_pos;
      rd_en        = 1'b0;
      if (dp_cmd.load) begin
         status_in = STATUS_OK;
         rd_sel_in = 1'b0;
         case (cmd_in)
            CMD_ADD_FRONT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  front_pos_in = front_dec;
                  wr_en        = 1'b1;
                  wr_addr      = front_dec;
                  cnt_in       = cnt_ff + CW'(1);
                  front_val_in = value;
                  if (cnt_ff == '0) begin
                     back_val_in = value;
                  end
               end
            end
            CMD_ADD_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = back_pos;
                  cnt_in      = cnt_ff + CW'(1);
                  back_val_in = value;
                  if (cnt_ff == '0) begin
                     front_val_in = value;
                  end
               end
            end
            CMD_READ: begin
               if (in_range) begin
                  rd_en     = 1'b1;
                  rd_sel_in = 1'b1;
               end else begin
                  status_in = STATUS_RANGE;
               end
            end
            CMD_CLEAR: begin
               front_pos_in = '0;
               cnt_in       = '0;
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_pos_ff <= '0;
         cnt_ff       <= '0;
         status_ff    <= STATUS_OK;
         rd_sel_ff    <= 1'b0;
      end else begin
         front_pos_ff <= front_pos_in;
         cnt_ff       <= cnt_in;
         status_ff    <= status_in;
         rd_sel_ff    <= rd_sel_in;
      end
   end

   // Cached end values
   always_ff @(posedge clock) begin
      front_val_ff <= front_val_in;
      back_val_ff  <= back_val_in;
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value;
      end
      if (rd_en) begin
         rd_q_ff <= mem[read_pos];
      end
   end

   // Result fields
   assign read_value  = rd_sel_ff ? rd_q_ff : '0;
   assign is_empty    = (cnt_ff == '0);
   assign front_value = is_empty ? '0 : front_val_ff;
   assign back_value  = is_empty ? '0 : back_val_ff;
   assign count       = cnt_ff;
   assign status      = status_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load && full && (cmd_in == CMD_ADD_FRONT || cmd_in == CMD_ADD_BACK)
      |=> $stable(cnt_ff) && $stable(front_pos_ff) && status_ff == STATUS_FULL)
      else $error("push into full store changed state");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load && cmd_in == CMD_CLEAR |=> cnt_ff == '0 && front_pos_ff == '0)
      else $error("clear did not empty the store");

   a_range: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load && cmd_in == CMD_READ && !in_range
      |=> !rd_sel_ff && status_ff == STATUS_RANGE)
      else $error("out of range read not flagged");

endmodule

/* src/double_ended_queue_store_unit.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_store_unit
// Double-ended queue in a ring store with push front, push back, indexed
// read and clear; one response item for every request item.
// ----------------------------------------------------------------------------
// Each request item returns one response item in the cycle after it is
// accepted; a new request is taken in the same cycle the previous response
// is taken, so the unit sustains one item per clock when the response side
// does not stall. Results are registered, a read through the store's single
// registered read port; front and back values are kept in registers beside the
// store. A push into a full store is dropped with status full, a read at or
// beyond the count returns zero with status range, and front and back read as
// zero when the queue is empty. No clearing pass is needed after reset.
module double_ended_queue_store_unit
   import dqs_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int CAPACITY   = 64
) (
   input  logic        clock,
   input  logic        reset,
   dqs_req_if.sink     req,
   dqs_rsp_if.source   rsp
);

   dp_cmd_type dp_cmd;

   // Handshake controller
   dqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .dp_cmd    (dp_cmd)
   );

   // Store and result datapath
   dqs_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .CAPACITY   (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .cmd         (req.cmd),
      .value       (req.value),
      .index       (req.index),
      .read_value  (rsp.read_value),
      .front_value (rsp.front_value),
      .back_value  (rsp.back_value),
      .count       (rsp.count),
      .is_empty    (rsp.is_empty),
      .status      (rsp.status)
   );

endmodule

/* bench/tb_double_ended_queue_store_unit.sv */
// ----------------------------------------------------------------------------
// tb_double_ended_queue_store_unit
// Self-checking bench for the double-ended queue store unit. A driver feeds
// command items from a queue filled at start-up; a monitor predicts every
// response from its own model of the ring and checks it field by field.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_store_unit
   import dqs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW          = 32;
   localparam int DEPTH       = 64;
   localparam int CNT_W       = 7;
   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 160;
   localparam int STEADY_LO   = 250;
   localparam int STEADY_HI   = 330;
   localparam int CYCLE_LIMIT = 200000;

   // One command item; a pause marker is not sent but waits for all replies
   typedef struct {
      cmd_type           cmd;
      logic [DW-1:0]     value;
      logic [5:0]        index;
      bit                pause;
   } dq_cmd_type;

   typedef struct {
      logic [DW-1:0]     read_value;
      logic [DW-1:0]     front_value;
      logic [DW-1:0]     back_value;
      logic [CNT_W-1:0]  count;
      logic              is_empty;
      status_type        status;
   } dq_reply_type;

   logic clock;
   logic reset;

   dqs_req_if #(.DATA_WIDTH(DW)) req_if ();
   dqs_rsp_if #(.DATA_WIDTH(DW), .CAPACITY(DEPTH)) rsp_if ();

   double_ended_queue_store_unit #(
      .DATA_WIDTH(DW),
      .CAPACITY  (DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   // Bench state
   dq_cmd_type    command_queue[$];
   dq_reply_type  awaited_replies[$];
   int         queued_items;
   int         accepted_items;
   int         error_count;
   int         cycle_count;
   logic       req_fired;
   bit         waiting_drain;
   int         hold_left;
   bit         hold_used;

   // Model of the ring
   logic [DW-1:0]    ring [DEPTH];
   logic [5:0]       head_pos;
   logic [CNT_W-1:0] fill_level;

   // Clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Apply one command to the model and return the reply it should produce
   function automatic dq_reply_type apply_command(dq_cmd_type c);
      dq_reply_type  r;
      logic [5:0] last_pos;
      r.read_value = '0;
      r.status     = STATUS_OK;
      case (c.cmd)
         CMD_ADD_FRONT: begin
            if (fill_level >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               head_pos       = head_pos - 6'd1;
               ring[head_pos] = c.value;
               fill_level     = fill_level + 1'b1;
            end
         end
         CMD_ADD_BACK: begin
            if (fill_level >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               ring[head_pos + fill_level[5:0]] = c.value;
               fill_level = fill_level + 1'b1;
            end
         end
         CMD_READ: begin
            if (CNT_W'(c.index) >= fill_level) r.status = STATUS_RANGE;
            else r.read_value = ring[head_pos + c.index];
         end
         default: begin
            head_pos   = '0;
            fill_level = '0;
         end
      endcase
      // 64 entries wrap to zero in six bits, so minus one still lands on the back
      last_pos = head_pos + fill_level[5:0] - 6'd1;
      if (fill_level == 0) begin
         r.front_value = '0;
         r.back_value  = '0;
      end else begin
         r.front_value = ring[head_pos];
         r.back_value  = ring[last_pos];
      end
      r.count    = fill_level;
      r.is_empty = (fill_level == 0);
      return r;
   endfunction

   function automatic void note_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endfunction

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(cmd_type cmd, logic [DW-1:0] value, logic [5:0] index);
      dq_cmd_type c;
      c.cmd   = cmd;
      c.value = value;
      c.index = index;
      c.pause = 1'b0;
      command_queue.insert(command_queue.size(), c);
      queued_items++;
   endtask

   task automatic add_pause();
      dq_cmd_type c;
      c.cmd   = CMD_READ;
      c.value = '0;
      c.index = '0;
      c.pause = 1'b1;
      command_queue.insert(command_queue.size(), c);
   endtask

   // Driver: new item at the falling edge once the last one was taken
   always @(negedge clock) begin
      dq_cmd_type c;
      logic    nv;
      bit      steady;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         nv     = 1'b0;
         steady = (accepted_items >= STEADY_LO) && (accepted_items < STEADY_HI);
         if (waiting_drain) begin
            if (awaited_replies.size() == 0) waiting_drain = 1'b0;
         end else if (command_queue.size() > 0 && (steady || $urandom_range(99) >= 27)) begin
            c = command_queue.pop_front();
            if (c.pause) begin
               waiting_drain = 1'b1;
            end else begin
               nv = 1'b1;
               req_if.cmd   <= c.cmd;
               req_if.value <= c.value;
               req_if.index <= c.index;
            end
         end
         req_if.valid <= nv;
      end
   end

   // Response ready, with one long hold-off while the sender keeps going
   always @(negedge clock) begin
      logic r;
      bit   steady;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         steady = (accepted_items >= STEADY_LO) && (accepted_items < STEADY_HI);
         if (!hold_used && accepted_items >= HOLD_AT) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
         end else begin
            r = steady || ($urandom_range(99) >= 27);
         end
         rsp_if.ready <= r;
      end
   end

   // Monitor: check replies, predict accepted items
   always @(posedge clock) begin
      dq_reply_type want;
      dq_reply_type got;
      dq_cmd_type   c;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.read_value  = rsp_if.read_value;
            got.front_value = rsp_if.front_value;
            got.back_value  = rsp_if.back_value;
            got.count       = rsp_if.count;
            got.is_empty    = rsp_if.is_empty;
            got.status      = status_type'(rsp_if.status);
            if (awaited_replies.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("unexpected reply item, none awaited");
            end else begin
               want = awaited_replies.pop_front();
               note_field("read_value", want.read_value, got.read_value);
               note_field("front_value", want.front_value, got.front_value);
               note_field("back_value", want.back_value, got.back_value);
               note_field("count", DW'(want.count), DW'(got.count));
               note_field("is_empty", DW'(want.is_empty), DW'(got.is_empty));
               note_field("status", DW'(want.status), DW'(got.status));
            end
         end
         if (req_if.valid && req_if.ready) begin
            c.cmd   = cmd_type'(req_if.cmd);
            c.value = req_if.value;
            c.index = req_if.index;
            c.pause = 1'b0;
            awaited_replies.insert(awaited_replies.size(), apply_command(c));
            accepted_items++;
         end
         req_fired <= req_if.valid && req_if.ready;
      end
   end

   // Stimulus and end of run
   initial begin
      int  kind;
      int  n;
      int  k;
      int  r;
      bit  first_fill;
      bit  mid_pause;

      req_if.valid = 1'b0;
      req_if.cmd   = CMD_READ;
      req_if.value = '0;
      req_if.index = '0;
      rsp_if.ready = 1'b0;
      reset        = 1'b1;
      queued_items   = 0;
      accepted_items = 0;
      error_count    = 0;
      cycle_count    = 0;
      waiting_drain  = 1'b0;
      hold_left      = 0;
      hold_used      = 1'b0;
      head_pos       = '0;
      fill_level     = '0;
      for (k = 0; k < DEPTH; k++) ring[k] = '0;

      // Directed: empty reads, both push ends, wrap of front, bounds, clear
      add_item(CMD_READ,       '0,            6'd0);
      add_item(CMD_ADD_BACK,   '0,            6'd63);
      add_item(CMD_ADD_BACK,   '1,            6'd0);
      add_item(CMD_ADD_FRONT,  32'hA5A5A5A5,  6'd0);
      add_item(CMD_ADD_FRONT,  32'h5A5A5A5A,  6'd21);
      add_item(CMD_READ,       '1,            6'd0);
      add_item(CMD_READ,       '0,            6'd3);
      add_item(CMD_READ,       '0,            6'd4);
      add_item(CMD_READ,       '0,            6'd63);
      add_item(CMD_CLEAR,      '1,            6'd42);
      add_item(CMD_READ,       '0,            6'd0);
      add_item(CMD_ADD_FRONT,  '1,            6'd0);
      add_item(CMD_READ,       '0,            6'd0);
      add_item(CMD_ADD_BACK,   32'h00000001,  6'd0);
      add_item(CMD_READ,       '0,            6'd1);
      add_item(CMD_READ,       '0,            6'd2);
      add_item(CMD_CLEAR,      '0,            6'd0);
      add_item(CMD_ADD_BACK,   32'h80000000,  6'd0);
      add_item(CMD_READ,       '0,            6'd0);
      add_pause();

      // Random: mostly fills to capacity and mixed bursts, some raw noise
      first_fill = 1'b1;
      mid_pause  = 1'b0;
      queued_items = 0;
      while (queued_items < RANDOM_ITEMS) begin
         kind = first_fill ? 0 : $urandom_range(9);
         first_fill = 1'b0;
         if (kind < 3) begin
            add_item(CMD_CLEAR, pick_value(), 6'($urandom_range(63)));
            for (k = 0; k < DEPTH; k++)
               add_item($urandom_range(1) ? CMD_ADD_FRONT : CMD_ADD_BACK,
                        pick_value(), 6'($urandom_range(63)));
            n = $urandom_range(2, 5);
            for (k = 0; k < n; k++)
               add_item($urandom_range(1) ? CMD_ADD_FRONT : CMD_ADD_BACK,
                        pick_value(), 6'($urandom_range(63)));
            n = $urandom_range(4, 10);
            for (k = 0; k < n; k++) begin
               r = $urandom_range(3);
               add_item(CMD_READ, pick_value(),
                        (r == 0) ? 6'd0 : (r == 1) ? 6'd63 : 6'($urandom_range(63)));
            end
         end else if (kind < 9) begin
            n = $urandom_range(10, 30);
            for (k = 0; k < n; k++) begin
               r = $urandom_range(99);
               if (r < 25)
                  add_item(CMD_ADD_FRONT, pick_value(), 6'($urandom_range(63)));
               else if (r < 50)
                  add_item(CMD_ADD_BACK, pick_value(), 6'($urandom_range(63)));
               else if (r < 92)
                  add_item(CMD_READ, pick_value(),
                           $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63)));
               else
                  add_item(CMD_CLEAR, pick_value(), 6'($urandom_range(63)));
            end
         end else begin
            n = $urandom_range(3, 8);
            for (k = 0; k < n; k++)
               add_item(cmd_type'($urandom_range(3)), $urandom, 6'($urandom_range(63)));
         end
         if (!mid_pause && queued_items >= RANDOM_ITEMS / 2) begin
            mid_pause = 1'b1;
            add_pause();
         end
      end

      // Release reset at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all items to be sent and every reply to come back
      while (command_queue.size() != 0 || waiting_drain || req_if.valid
             || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0 && awaited_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
